>>> rtl/core/ogha_pkg.sv
// types, constants and register codes shared by the hit accumulator modules
`default_nettype none
package ogha_pkg;

   localparam int GRID_SIDE = 1024;
   localparam int GRID_BITS = $clog2(GRID_SIDE);
   localparam int ADDR_BITS = 2 * GRID_BITS;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;

   localparam int POS_BITS     = 24;
   localparam int INV_RES_BITS = 16;
   localparam int CROP_BITS    = 11;
   localparam int LOCAL_BITS   = 10;
   localparam int COUNT_BITS   = 2;
   localparam int VALUE_BITS   = 8;
   localparam int FRAC_BITS    = 16;

   localparam int PROD_BITS  = POS_BITS + INV_RES_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int COORD_BITS = SUM_BITS - FRAC_BITS;
   localparam int IDX_BITS   = COORD_BITS + GRID_BITS + 1;
   localparam int RD_BITS    = COORD_BITS + 2;

   localparam logic signed [SUM_BITS-1:0] ORIGIN_Q16 =
      SUM_BITS'(GRID_SIDE / 2) << FRAC_BITS;
   localparam logic signed [SUM_BITS-1:0] TRUNC_BIAS = (SUM_BITS'(1) << FRAC_BITS) - 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 2'd3;
   localparam logic [COUNT_BITS-1:0] COUNT_SHOW = 2'd2;
   localparam logic [VALUE_BITS-1:0] CELL_FULL  = 8'd250;

   localparam logic [INV_RES_BITS-1:0] INV_RES_RESET = 16'd640;
   localparam logic [CROP_BITS-1:0]    CROP_RESET    = 11'd300;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = INV_RES_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_RES   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CROP_SIZE = 1'b1;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                         opcode;
      logic signed [POS_BITS-1:0]   pos_x;
      logic signed [POS_BITS-1:0]   pos_y;
      logic [LOCAL_BITS-1:0]        local_col;
      logic [LOCAL_BITS-1:0]        local_row;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] cell_value;
      logic [COUNT_BITS-1:0] cell_count;
      logic                  in_range;
   } rsp_item_type;

   typedef struct packed {
      logic                 opcode;
      logic [ADDR_BITS-1:0] addr;
      logic                 in_range;
   } mid_item_type;

endpackage
`default_nettype wire

>>> rtl/core/ogha_front.sv
// front part: configuration registers, scaling and cell address classification
`default_nettype none
module ogha_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [ogha_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ogha_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  ogha_pkg::req_item_type                 in_item,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output ogha_pkg::mid_item_type                 out_item
);
   import ogha_pkg::*;

   logic [INV_RES_BITS-1:0] inv_res_ff, inv_res_in;
   logic [CROP_BITS-1:0]    crop_ff, crop_in;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;

   logic                        s1_op_ff, s1_op_in;
   logic signed [PROD_BITS-1:0] s1_px_ff, s1_px_in, s1_py_ff, s1_py_in;
   logic [LOCAL_BITS-1:0]       s1_col_ff, s1_col_in, s1_row_ff, s1_row_in;

   logic                         s2_op_ff, s2_op_in;
   logic signed [COORD_BITS-1:0] s2_sx_ff, s2_sx_in, s2_sy_ff, s2_sy_in;
   logic [LOCAL_BITS-1:0]        s2_col_ff, s2_col_in, s2_row_ff, s2_row_in;

   mid_item_type s3_item_ff, s3_item_in, s3_calc;

   logic signed [PROD_BITS-1:0] mul_x, mul_y;
   logic signed [SUM_BITS-1:0]  px_ext, py_ext, cs_ext, top_bias, left_bias;
   logic signed [SUM_BITS-1:0]  add_x, add_y, sum_x, sum_y;
   logic signed [IDX_BITS-1:0]  idx;
   logic signed [RD_BITS-1:0]   rd_x, rd_y;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

   // configuration
   always_comb begin
      inv_res_in = inv_res_ff;
      crop_in    = crop_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_INV_RES:   inv_res_in = csr_data[INV_RES_BITS-1:0];
            CSR_CROP_SIZE: crop_in    = csr_data[CROP_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // stage 1: scale by inverse resolution
   assign mul_x = $signed(in_item.pos_x) * $signed({1'b0, inv_res_ff});
   assign mul_y = $signed(in_item.pos_y) * $signed({1'b0, inv_res_ff});

   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s1_op_in    = s1_ready ? in_item.opcode : s1_op_ff;
      s1_px_in    = s1_ready ? mul_x : s1_px_ff;
      s1_py_in    = s1_ready ? mul_y : s1_py_ff;
      s1_col_in   = s1_ready ? in_item.local_col : s1_col_ff;
      s1_row_in   = s1_ready ? in_item.local_row : s1_row_ff;
   end

   // stage 2: origin offset and rounding to whole cells
   assign px_ext    = {s1_px_ff[PROD_BITS-1], s1_px_ff};
   assign py_ext    = {s1_py_ff[PROD_BITS-1], s1_py_ff};
   assign cs_ext    = $signed({(SUM_BITS-CROP_BITS)'(0), crop_ff});
   assign top_bias  = (cs_ext + SUM_BITS'(1)) <<< (FRAC_BITS - 1);
   assign left_bias = (SUM_BITS'(1) - cs_ext) <<< (FRAC_BITS - 1);

   always_comb begin
      if (s1_op_ff == OP_READ) begin
         add_x = left_bias;
         add_y = top_bias;
      end else begin
         add_x = px_ext[SUM_BITS-1] ? TRUNC_BIAS : '0;
         add_y = py_ext[SUM_BITS-1] ? TRUNC_BIAS : '0;
      end
      sum_x = px_ext + ORIGIN_Q16 + add_x;
      sum_y = py_ext + ORIGIN_Q16 + add_y;
   end

   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_op_in    = s2_ready ? s1_op_ff : s2_op_ff;
      s2_sx_in    = s2_ready ? sum_x[SUM_BITS-1:FRAC_BITS] : s2_sx_ff;
      s2_sy_in    = s2_ready ? sum_y[SUM_BITS-1:FRAC_BITS] : s2_sy_ff;
      s2_col_in   = s2_ready ? s1_col_ff : s2_col_ff;
      s2_row_in   = s2_ready ? s1_row_ff : s2_row_ff;
   end

   // stage 3: cell address and range check
   assign idx  = ($signed(IDX_BITS'(s2_sy_ff)) <<< GRID_BITS) + $signed(IDX_BITS'(s2_sx_ff));
   assign rd_x = $signed(RD_BITS'(s2_sx_ff)) + $signed({(RD_BITS-LOCAL_BITS)'(0), s2_col_ff});
   assign rd_y = $signed(RD_BITS'(s2_sy_ff))
               - $signed({(RD_BITS-CROP_BITS)'(0), crop_ff})
               + $signed({(RD_BITS-LOCAL_BITS)'(0), s2_row_ff});

   always_comb begin
      s3_calc.opcode = s2_op_ff;
      if (s2_op_ff == OP_READ) begin
         s3_calc.addr     = {rd_y[GRID_BITS-1:0], rd_x[GRID_BITS-1:0]};
         s3_calc.in_range = (rd_x[RD_BITS-1:GRID_BITS] == '0)
                         && (rd_y[RD_BITS-1:GRID_BITS] == '0);
      end else begin
         s3_calc.addr     = idx[ADDR_BITS-1:0];
         s3_calc.in_range = (idx[IDX_BITS-1:ADDR_BITS] == '0);
      end
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
      s3_item_in  = s3_ready ? s3_calc : s3_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_res_ff  <= INV_RES_RESET;
         crop_ff     <= CROP_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         inv_res_ff  <= inv_res_in;
         crop_ff     <= crop_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_px_ff   <= s1_px_in;
      s1_py_ff   <= s1_py_in;
      s1_col_ff  <= s1_col_in;
      s1_row_ff  <= s1_row_in;
      s2_op_ff   <= s2_op_in;
      s2_sx_ff   <= s2_sx_in;
      s2_sy_ff   <= s2_sy_in;
      s2_col_ff  <= s2_col_in;
      s2_row_ff  <= s2_row_in;
      s3_item_ff <= s3_item_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/ogha_queue.sv
// short queue of classified items between the front and back parts
`default_nettype none
module ogha_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  ogha_pkg::mid_item_type push_item,
   input  logic                   pop,
   output logic                   empty,
   output ogha_pkg::mid_item_type pop_item
);
   import ogha_pkg::*;

   mid_item_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign full     = (cnt_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QUEUE_PTR_BITS+1)'(do_push) - (QUEUE_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/ogha_back.sv
// back part: hit count memory, clearing pass, read-modify-write and result queue
`default_nettype none
module ogha_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_pop,
   input  ogha_pkg::mid_item_type in_item,
   output logic                   clearing,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ogha_pkg::rsp_item_type rsp_item
);
   import ogha_pkg::*;

   logic [COUNT_BITS-1:0] hit_mem [CELLS];
   logic [COUNT_BITS-1:0] rd_count_ff;

   logic [ADDR_BITS:0]    clr_cnt_ff, clr_cnt_in;
   logic                  b_valid_ff, b_valid_in;
   mid_item_type          b_item_ff;
   logic                  last_valid_ff, last_valid_in;
   logic [ADDR_BITS-1:0]  last_addr_ff, last_addr_in;
   logic [COUNT_BITS-1:0] last_count_ff, last_count_in;

   logic                  go, space, wr_cell;
   logic [COUNT_BITS-1:0] old_count, new_count;
   rsp_item_type          result;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   rsp_item_type              rsp_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] rwr_ptr_ff, rwr_ptr_in, rrd_ptr_ff, rrd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   rcnt_ff, rcnt_in;
   logic                      rsp_take;

   assign clearing = !clr_cnt_ff[ADDR_BITS];
   assign space    = ({1'b0, rcnt_ff} + (QUEUE_PTR_BITS+2)'(b_valid_ff))
                   < (QUEUE_PTR_BITS+2)'(QUEUE_DEPTH);
   assign go       = in_valid && space && !clearing;
   assign in_pop   = go;

   // forward the latest write over a stale read
   assign old_count = (last_valid_ff && (last_addr_ff == b_item_ff.addr))
                    ? last_count_ff : rd_count_ff;
   assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
   assign wr_cell   = b_valid_ff && (b_item_ff.opcode == OP_ACCUM) && b_item_ff.in_range;

   always_comb begin
      result = '0;
      if (b_item_ff.in_range) begin
         if (b_item_ff.opcode == OP_ACCUM) begin
            result.cell_count = new_count;
         end else begin
            result.cell_count = old_count;
            result.cell_value = (old_count > COUNT_SHOW) ? CELL_FULL : '0;
         end
         result.in_range = 1'b1;
      end
   end

   always_comb begin
      clr_cnt_in    = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      b_valid_in    = go;
      last_valid_in = last_valid_ff || wr_cell;
      last_addr_in  = wr_cell ? b_item_ff.addr : last_addr_ff;
      last_count_in = wr_cell ? new_count : last_count_ff;
      mem_we        = clearing || wr_cell;
      mem_waddr     = clearing ? clr_cnt_ff[ADDR_BITS-1:0] : b_item_ff.addr;
      mem_wdata     = clearing ? '0 : new_count;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hit_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rd_count_ff <= hit_mem[in_item.addr];
      end
   end

   // result queue
   assign rsp_empty = (rcnt_ff == '0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_item  = rsp_mem[rrd_ptr_ff];

   always_comb begin
      rwr_ptr_in = b_valid_ff ? rwr_ptr_ff + 1'b1 : rwr_ptr_ff;
      rrd_ptr_in = rsp_take ? rrd_ptr_ff + 1'b1 : rrd_ptr_ff;
      rcnt_in    = rcnt_ff + (QUEUE_PTR_BITS+1)'(b_valid_ff) - (QUEUE_PTR_BITS+1)'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         rsp_mem[rwr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         b_valid_ff    <= 1'b0;
         last_valid_ff <= 1'b0;
         rwr_ptr_ff    <= '0;
         rrd_ptr_ff    <= '0;
         rcnt_ff       <= '0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         b_valid_ff    <= b_valid_in;
         last_valid_ff <= last_valid_in;
         rwr_ptr_ff    <= rwr_ptr_in;
         rrd_ptr_ff    <= rrd_ptr_in;
         rcnt_ff       <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         b_item_ff <= in_item;
      end
      last_addr_ff  <= last_addr_in;
      last_count_ff <= last_count_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/occupancy_grid_hit_accumulator.sv
// top level of the occupancy grid hit accumulator
//
// channel   direction  handshake              payload
// req_      in         push / full            req_item  (ogha_pkg::req_item_type)
// rsp_      out        pop / empty            rsp_item  (ogha_pkg::rsp_item_type)
// csr_      in         csr_write, csr_index   csr_data  (16 bit)
//
// one item per cycle sustained unless results back up or clearing runs; the cell memory
// read-modify-write in the back part, with forwarding of the last write, sets that figure
// a result passes the front stages, the middle queue, b_item_ff and the result queue
// after reset a clearing pass zeroes all 1048576 cells of the grid, with full held high
// either side may stall: the middle and result queues decouple front and back
`default_nettype none
module occupancy_grid_hit_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [ogha_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ogha_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                req_push,
   output logic                                req_full,
   input  ogha_pkg::req_item_type              req_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ogha_pkg::rsp_item_type              rsp_item
);
   import ogha_pkg::*;

   logic         front_ready, front_valid;
   mid_item_type front_item, q_item;
   logic         q_full, q_empty, q_pop;
   logic         clearing;

   assign req_full = clearing || !front_ready;

   ogha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (req_push && !clearing),
      .in_ready  (front_ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (!q_full),
      .out_item  (front_item)
   );

   ogha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .full      (q_full),
      .push_item (front_item),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_item)
   );

   ogha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_pop    (q_pop),
      .in_item   (q_item),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("input not held off after reset");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> rsp_empty)
      else $error("result present during clearing pass");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("middle queue full and empty together");

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("back part took an item during clearing pass");

endmodule
`default_nettype wire

>>> tb/tb_occupancy_grid_hit_accumulator.sv
// testbench for the occupancy grid hit accumulator: random and directed items checked against a predictor
`default_nettype none
module tb_occupancy_grid_hit_accumulator;
   import ogha_pkg::*;

   localparam longint Q16_ONE    = 65536;
   localparam longint GRID_ORG   = GRID_SIDE / 2;
   localparam int     HOLD_CYCLES = 300;
   localparam int     SETTLE_CYCLES = 12;

   class hit_grid_scoreboard;
      bit [COUNT_BITS-1:0] cells [0:CELLS-1];
      int                  inv_res;
      int                  crop;
      rsp_item_type        expected_cells [$];
      int                  errors;

      function new();
         inv_res = INV_RES_RESET;
         crop    = CROP_RESET;
         errors  = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_INV_RES: begin
               inv_res = data;
            end
            CSR_CROP_SIZE: begin
               crop = data[CROP_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      static function longint floor_q16(longint v);
         if (v >= 0) begin
            return v / Q16_ONE;
         end
         return -((-v + Q16_ONE - 1) / Q16_ONE);
      endfunction

      function void predict_cell(req_item_type r);
         longint px;
         longint py;
         longint x;
         longint y;
         longint idx;
         longint top;
         longint left;
         rsp_item_type e;
         px = longint'(r.pos_x) * longint'(inv_res);
         py = longint'(r.pos_y) * longint'(inv_res);
         e = '0;
         if (r.opcode == OP_ACCUM) begin
            // division of longint truncates toward zero
            x = px / Q16_ONE + GRID_ORG;
            y = py / Q16_ONE + GRID_ORG;
            idx = y * GRID_SIDE + x;
            if (idx >= 0 && idx < CELLS) begin
               if (cells[idx] != COUNT_MAX) begin
                  cells[idx] = cells[idx] + 1'b1;
               end
               e.cell_count = cells[idx];
               e.in_range = 1'b1;
            end
         end else begin
            top  = floor_q16(py + GRID_ORG * Q16_ONE + (longint'(crop) + 1) * (Q16_ONE / 2));
            left = floor_q16(px + GRID_ORG * Q16_ONE + (1 - longint'(crop)) * (Q16_ONE / 2));
            x = left + longint'(r.local_col);
            y = top - longint'(crop) + longint'(r.local_row);
            if (x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE) begin
               e.cell_count = cells[y * GRID_SIDE + x];
               e.cell_value = (e.cell_count > COUNT_SHOW) ? CELL_FULL : '0;
               e.in_range = 1'b1;
            end
         end
         expected_cells.insert(expected_cells.size(), e);
      endfunction

      function void check_cell(rsp_item_type r);
         rsp_item_type e;
         if (expected_cells.size() == 0) begin
            $error("unexpected item: cell_value %0d cell_count %0d in_range %0d",
                   r.cell_value, r.cell_count, r.in_range);
            errors++;
            return;
         end
         e = expected_cells.pop_front();
         if (r.cell_value !== e.cell_value) begin
            $error("cell_value: expected %0d, got %0d", e.cell_value, r.cell_value);
            errors++;
         end
         if (r.cell_count !== e.cell_count) begin
            $error("cell_count: expected %0d, got %0d", e.cell_count, r.cell_count);
            errors++;
         end
         if (r.in_range !== e.in_range) begin
            $error("in_range: expected %0d, got %0d", e.in_range, r.in_range);
            errors++;
         end
      endfunction

      function int waiting();
         return expected_cells.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      req_push = 1'b0;
   logic                      req_full;
   req_item_type              req_item = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   rsp_item_type              rsp_item;

   hit_grid_scoreboard sb = new();
   bit hold_req = 1'b0;

   occupancy_grid_hit_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            sb.check_cell(rsp_item);
         end
         if (req_push && !req_full) begin
            sb.predict_cell(req_item);
         end
      end
   end

   // result side stalls on its own pattern, with one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 50;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            case (mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= ($urandom_range(0, 1) == 0);
               default: rsp_pop <= ($urandom_range(0, 4) == 0);
            endcase
            @(negedge clock);
            mode_left--;
            if (mode_left <= 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_item_type point_item(int x, int y);
      req_item_type it;
      it = '0;
      it.opcode = OP_ACCUM;
      it.pos_x = POS_BITS'(x);
      it.pos_y = POS_BITS'(y);
      return it;
   endfunction

   function automatic req_item_type read_item(int x, int y, int col, int row);
      req_item_type it;
      it = '0;
      it.opcode = OP_READ;
      it.pos_x = POS_BITS'(x);
      it.pos_y = POS_BITS'(y);
      it.local_col = LOCAL_BITS'(col);
      it.local_row = LOCAL_BITS'(row);
      return it;
   endfunction

   // most items land near the origin so that cells saturate and reads find them
   function automatic req_item_type random_item(int inv, int crop);
      req_item_type it;
      longint lim;
      int kind;
      int span;
      kind = $urandom_range(0, 99);
      lim = (inv == 0) ? 64'd8388607 : (9 * Q16_ONE) / inv;
      if (lim > 8388607) begin
         lim = 8388607;
      end
      span = (crop + 1 > 1023) ? 1023 : crop + 1;
      it = '0;
      if (kind < 80) begin
         it.opcode = (kind < 45) ? OP_ACCUM : OP_READ;
         it.pos_x = POS_BITS'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
         it.pos_y = POS_BITS'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
         if ($urandom_range(0, 9) == 0) begin
            it.local_col = LOCAL_BITS'($urandom);
            it.local_row = LOCAL_BITS'($urandom);
         end else begin
            it.local_col = LOCAL_BITS'($urandom_range(0, span));
            it.local_row = LOCAL_BITS'($urandom_range(0, span));
         end
      end else begin
         it.opcode = 1'($urandom_range(0, 1));
         it.pos_x = POS_BITS'($urandom);
         it.pos_y = POS_BITS'($urandom);
         it.local_col = LOCAL_BITS'($urandom);
         it.local_row = LOCAL_BITS'($urandom);
      end
      return it;
   endfunction

   task automatic send(input req_item_type it);
      req_item <= it;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.waiting() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(input int inv, input int crop);
      csr_write <= 1'b1;
      csr_index <= CSR_INV_RES;
      csr_data  <= CSR_DATA_BITS'(inv);
      @(posedge clock);
      sb.set_reg(CSR_INV_RES, CSR_DATA_BITS'(inv));
      @(negedge clock);
      csr_index <= CSR_CROP_SIZE;
      // upper bits beyond the crop width are don't care
      csr_data  <= {5'($urandom), CROP_BITS'(crop)};
      @(posedge clock);
      sb.set_reg(CSR_CROP_SIZE, csr_data);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input int n, input bit hold, input bit pause_mid, input bit steady);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
         if (hold && i == 4) begin
            hold_req = 1'b1;
         end
         if (pause_mid && i == n / 2) begin
            drain();
         end
         send(random_item(sb.inv_res, sb.crop));
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   endtask

   initial begin
      int inv_set [8];
      int crop_set [8];
      inv_set  = '{256, 65535, 1, 0, 640, 128, 1000, 0};
      crop_set = '{8, 1, 1024, 0, 2047, 16, 3, 0};
      inv_set[7]  = $urandom_range(0, 65535);
      crop_set[7] = $urandom_range(0, 2047);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values, saturation at the origin cell
      repeat (4) send(point_item(0, 0));
      send(read_item(0, 0, 150, 150));
      send(read_item(0, 0, 0, 0));
      drain();

      write_regs(256, 4);
      send(point_item(8388607, 8388607));
      send(point_item(-8388608, -8388608));
      send(point_item(-517 * 256, 88 * 256));
      send(point_item(600 * 256, -100 * 256));
      send(point_item(-512 * 256, -512 * 256));
      send(point_item(511 * 256 + 255, 511 * 256));
      send(point_item(-1, -255));
      send(read_item(-130688, -130688, 0, 0));
      send(read_item(8388607, 8388607, 1023, 1023));
      send(read_item(-8388608, -8388608, 0, 0));
      send(read_item(0, 0, 1023, 1023));
      send(read_item(0, 0, 10, 3));
      send(read_item(-1, -1, 2, 2));
      drain();

      for (int p = 0; p < 8; p++) begin
         write_regs(inv_set[p], crop_set[p]);
         run_phase(160, p == 2, p == 4, p == 5);
         drain();
      end

      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
